// File: hdl/rlq_pkg.sv
// ----------------------------------------------------------------------------
// rlq_pkg: shared types and constants for the three-level ready queue
// Level codes, action codes, sequencer states, memory request word and
// circular pointer helpers.
// ----------------------------------------------------------------------------
package rlq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int AW          = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);

	localparam int ID_W     = 8;
	localparam int PRIO_W   = 8;
	localparam int KEY_W    = 16;
	localparam int ENTRY_W  = KEY_W + ID_W;
	localparam int L2_W     = PRIO_W + ID_W;

	localparam logic [PRIO_W-1:0] PRIO_L3_MAX = 8'd49;
	localparam logic [PRIO_W-1:0] PRIO_L2_MAX = 8'd99;
	localparam logic [PRIO_W-1:0] PRIO_L1_MAX = 8'd149;

	localparam logic [1:0] LVL_NONE  = 2'd0;
	localparam logic [1:0] LVL_ONE   = 2'd1;
	localparam logic [1:0] LVL_TWO   = 2'd2;
	localparam logic [1:0] LVL_THREE = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_PLACE,
		ST_POP
	} state_t;

	// request from the sequencer to the level memories
	typedef struct packed {
		logic               we;
		logic [1:0]         lvl;     // memory written this cycle
		logic [1:0]         rd_lvl;  // memory whose read data is used
		logic [AW-1:0]      waddr;
		logic [AW-1:0]      raddr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == '0) begin
			r = AW'(QUEUE_DEPTH - 1);
		end else begin
			r = p - AW'(1);
		end
		return r;
	endfunction

endpackage

// File: hdl/rlq_ram.sv
// ----------------------------------------------------------------------------
// rlq_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rlq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/rlq_ctrl.sv
// ----------------------------------------------------------------------------
// rlq_ctrl: sequencer for the ready queue
// Keeps head, tail and count of each circular level, and runs the sorted
// insert walk with one key comparator, one entry per cycle from the tail.
// ----------------------------------------------------------------------------
module rlq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          action,
	input  logic [rlq_pkg::ID_W-1:0]      thread_id,
	input  logic [rlq_pkg::PRIO_W-1:0]    priority_req,
	input  logic [rlq_pkg::KEY_W-1:0]     burst_time,
	input  logic [rlq_pkg::ENTRY_W-1:0]   rd_entry,
	output rlq_pkg::mem_req_t             req,
	output logic                          busy,
	output logic                          done,
	output logic                          valid_res,
	output logic [rlq_pkg::ID_W-1:0]      chosen_id,
	output logic [1:0]                    level,
	output logic                          dropped
);

	localparam int AW = rlq_pkg::AW;
	localparam int CW = rlq_pkg::CW;

	rlq_pkg::state_t state_q, state_d;

	logic [AW-1:0] head_q [1:3];
	logic [AW-1:0] head_d [1:3];
	logic [AW-1:0] tail_q [1:3];
	logic [AW-1:0] tail_d [1:3];
	logic [CW-1:0] count_q [1:3];
	logic [CW-1:0] count_d [1:3];

	logic [1:0]                   op_lvl_q, op_lvl_d;
	logic [rlq_pkg::KEY_W-1:0]    key_q, key_d;
	logic [rlq_pkg::ID_W-1:0]     id_q, id_d;
	logic [AW-1:0]                wa_q, wa_d;
	logic [AW-1:0]                ra_q, ra_d;
	logic [CW-1:0]                k_q, k_d;

	logic                         done_q, done_d;
	logic                         valid_q, valid_d;
	logic [rlq_pkg::ID_W-1:0]     chosen_q, chosen_d;
	logic [1:0]                   level_q, level_d;
	logic                         drop_q, drop_d;

	logic [1:0]                   ins_lvl, pop_lvl, tgt_lvl;
	logic [AW-1:0]                tgt_head, tgt_tail;
	logic [CW-1:0]                tgt_cnt;
	logic [rlq_pkg::KEY_W-1:0]    new_key;
	logic                         full;
	logic                         key_gt;

	// level decode
	always_comb begin
		if (priority_req > rlq_pkg::PRIO_L1_MAX) begin
			ins_lvl = rlq_pkg::LVL_NONE;
		end else if (priority_req > rlq_pkg::PRIO_L2_MAX) begin
			ins_lvl = rlq_pkg::LVL_ONE;
		end else if (priority_req > rlq_pkg::PRIO_L3_MAX) begin
			ins_lvl = rlq_pkg::LVL_TWO;
		end else begin
			ins_lvl = rlq_pkg::LVL_THREE;
		end

		if (count_q[1] != '0) begin
			pop_lvl = rlq_pkg::LVL_ONE;
		end else if (count_q[2] != '0) begin
			pop_lvl = rlq_pkg::LVL_TWO;
		end else if (count_q[3] != '0) begin
			pop_lvl = rlq_pkg::LVL_THREE;
		end else begin
			pop_lvl = rlq_pkg::LVL_NONE;
		end

		tgt_lvl = (action == rlq_pkg::ACT_POP) ? pop_lvl : ins_lvl;

		unique case (tgt_lvl)
			rlq_pkg::LVL_ONE: begin
				tgt_head = head_q[1];
				tgt_tail = tail_q[1];
				tgt_cnt  = count_q[1];
			end
			rlq_pkg::LVL_TWO: begin
				tgt_head = head_q[2];
				tgt_tail = tail_q[2];
				tgt_cnt  = count_q[2];
			end
			rlq_pkg::LVL_THREE: begin
				tgt_head = head_q[3];
				tgt_tail = tail_q[3];
				tgt_cnt  = count_q[3];
			end
			default: begin
				tgt_head = '0;
				tgt_tail = '0;
				tgt_cnt  = '0;
			end
		endcase

		new_key = (ins_lvl == rlq_pkg::LVL_ONE) ? burst_time
			: {{(rlq_pkg::KEY_W - rlq_pkg::PRIO_W){1'b0}}, priority_req};
		full    = (tgt_cnt == CW'(rlq_pkg::QUEUE_DEPTH));
		// the shared comparator: stored key above the new one moves up
		key_gt  = (rd_entry[rlq_pkg::ENTRY_W-1:rlq_pkg::ID_W] > key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlq_pkg::ST_IDLE;
			done_q  <= 1'b0;
			for (int i = 1; i <= 3; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			for (int i = 1; i <= 3; i++) begin
				head_q[i]  <= head_d[i];
				tail_q[i]  <= tail_d[i];
				count_q[i] <= count_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		op_lvl_q <= op_lvl_d;
		key_q    <= key_d;
		id_q     <= id_d;
		wa_q     <= wa_d;
		ra_q     <= ra_d;
		k_q      <= k_d;
		valid_q  <= valid_d;
		chosen_q <= chosen_d;
		level_q  <= level_d;
		drop_q   <= drop_d;
	end

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		op_lvl_d = op_lvl_q;
		key_d    = key_q;
		id_d     = id_q;
		wa_d     = wa_q;
		ra_d     = ra_q;
		k_d      = k_q;
		done_d   = 1'b0;
		valid_d  = valid_q;
		chosen_d = chosen_q;
		level_d  = level_q;
		drop_d   = drop_q;

		req        = '0;
		req.rd_lvl = op_lvl_q;

		unique case (state_q)
			rlq_pkg::ST_IDLE: begin
				if (start) begin
					op_lvl_d = tgt_lvl;
					key_d    = new_key;
					id_d     = thread_id;
					valid_d  = 1'b0;
					chosen_d = '0;
					level_d  = tgt_lvl;
					drop_d   = 1'b0;
					if (action == rlq_pkg::ACT_POP) begin
						if (pop_lvl == rlq_pkg::LVL_NONE) begin
							done_d = 1'b1;
						end else begin
							req.raddr        = tgt_head;
							head_d[tgt_lvl]  = rlq_pkg::ptr_inc(tgt_head);
							count_d[tgt_lvl] = tgt_cnt - CW'(1);
							state_d          = rlq_pkg::ST_POP;
						end
					end else if (ins_lvl == rlq_pkg::LVL_NONE || full) begin
						drop_d = 1'b1;
						done_d = 1'b1;
					end else begin
						tail_d[tgt_lvl]  = rlq_pkg::ptr_inc(tgt_tail);
						count_d[tgt_lvl] = tgt_cnt + CW'(1);
						if (ins_lvl == rlq_pkg::LVL_THREE || tgt_cnt == '0) begin
							// FIFO level or empty sorted level: append
							req.we    = 1'b1;
							req.lvl   = tgt_lvl;
							req.waddr = tgt_tail;
							req.wdata = {new_key, thread_id};
							done_d    = 1'b1;
						end else begin
							req.raddr = rlq_pkg::ptr_dec(tgt_tail);
							wa_d      = tgt_tail;
							ra_d      = rlq_pkg::ptr_dec(tgt_tail);
							k_d       = tgt_cnt;
							state_d   = rlq_pkg::ST_WALK;
						end
					end
				end
			end
			rlq_pkg::ST_WALK: begin
				req.we    = 1'b1;
				req.lvl   = op_lvl_q;
				req.waddr = wa_q;
				if (key_gt) begin
					// shift this word up one slot, fetch the next lower one
					req.wdata = rd_entry;
					req.raddr = rlq_pkg::ptr_dec(ra_q);
					wa_d      = ra_q;
					ra_d      = rlq_pkg::ptr_dec(ra_q);
					k_d       = k_q - CW'(1);
					if (k_q == CW'(1)) begin
						state_d = rlq_pkg::ST_PLACE;
					end
				end else begin
					req.wdata = {key_q, id_q};
					done_d    = 1'b1;
					state_d   = rlq_pkg::ST_IDLE;
				end
			end
			rlq_pkg::ST_PLACE: begin
				req.we    = 1'b1;
				req.lvl   = op_lvl_q;
				req.waddr = wa_q;
				req.wdata = {key_q, id_q};
				done_d    = 1'b1;
				state_d   = rlq_pkg::ST_IDLE;
			end
			rlq_pkg::ST_POP: begin
				valid_d  = 1'b1;
				chosen_d = rd_entry[rlq_pkg::ID_W-1:0];
				done_d   = 1'b1;
				state_d  = rlq_pkg::ST_IDLE;
			end
			default: begin
				state_d = rlq_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != rlq_pkg::ST_IDLE);
	assign done      = done_q;
	assign valid_res = valid_q;
	assign chosen_id = chosen_q;
	assign level     = level_q;
	assign dropped   = drop_q;

endmodule

// File: hdl/three_level_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// three_level_ready_queue_unit: three-level ready queue
// Result on done in the cycle after the last step. Drop, empty pop, FIFO insert
// or insert into an empty sorted level finish in the start step; pop of a
// thread reads the head, then returns its id. Sorted insert walks the entries
// with a larger key from the tail, one entry per cycle, then places the new one.
// busy is high while a pop or sorted insert runs; the receiver takes done as shown.
// Reset clears all levels to empty at once; no clearing pass.
// ----------------------------------------------------------------------------
module three_level_ready_queue_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic [rlq_pkg::ID_W-1:0]   thread_id,
	input  logic [rlq_pkg::PRIO_W-1:0] priority_req,
	input  logic [rlq_pkg::KEY_W-1:0]  burst_time,
	output logic                       done,
	output logic                       valid_res,
	output logic [rlq_pkg::ID_W-1:0]   chosen_id,
	output logic [1:0]                 level,
	output logic                       dropped
);

	rlq_pkg::mem_req_t                req;
	logic [rlq_pkg::ENTRY_W-1:0]      rd_entry;
	logic [rlq_pkg::ENTRY_W-1:0]      l1_rdata;
	logic [rlq_pkg::L2_W-1:0]         l2_rdata;
	logic [rlq_pkg::ID_W-1:0]         l3_rdata;
	logic                             we1, we2, we3;

	rlq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.burst_time   (burst_time),
		.rd_entry     (rd_entry),
		.req          (req),
		.busy         (busy),
		.done         (done),
		.valid_res    (valid_res),
		.chosen_id    (chosen_id),
		.level        (level),
		.dropped      (dropped)
	);

	assign we1 = req.we && (req.lvl == rlq_pkg::LVL_ONE);
	assign we2 = req.we && (req.lvl == rlq_pkg::LVL_TWO);
	assign we3 = req.we && (req.lvl == rlq_pkg::LVL_THREE);

	// level 1 word: burst, id
	rlq_ram #(.WIDTH(rlq_pkg::ENTRY_W), .DEPTH(rlq_pkg::QUEUE_DEPTH)) u_l1_ram (
		.clk   (clk),
		.we    (we1),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.raddr (req.raddr),
		.rdata (l1_rdata)
	);

	// level 2 word: priority, id
	rlq_ram #(.WIDTH(rlq_pkg::L2_W), .DEPTH(rlq_pkg::QUEUE_DEPTH)) u_l2_ram (
		.clk   (clk),
		.we    (we2),
		.waddr (req.waddr),
		.wdata (req.wdata[rlq_pkg::L2_W-1:0]),
		.raddr (req.raddr),
		.rdata (l2_rdata)
	);

	// level 3 word: id only
	rlq_ram #(.WIDTH(rlq_pkg::ID_W), .DEPTH(rlq_pkg::QUEUE_DEPTH)) u_l3_ram (
		.clk   (clk),
		.we    (we3),
		.waddr (req.waddr),
		.wdata (req.wdata[rlq_pkg::ID_W-1:0]),
		.raddr (req.raddr),
		.rdata (l3_rdata)
	);

	always_comb begin
		unique case (req.rd_lvl)
			rlq_pkg::LVL_ONE: rd_entry = l1_rdata;
			rlq_pkg::LVL_TWO: rd_entry = {{(rlq_pkg::ENTRY_W - rlq_pkg::L2_W){1'b0}}, l2_rdata};
			default:          rd_entry = {{(rlq_pkg::ENTRY_W - rlq_pkg::ID_W){1'b0}}, l3_rdata};
		endcase
	end

endmodule
